// ===== design/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg: shared types and constants for the breakpoint patch table
// Request codes, controller states, result kinds and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam logic [31:0] BKPT_WORD      = 32'hE120_0070;

  typedef enum logic [2:0] {
    REQ_SET        = 3'd0,
    REQ_REMOVE     = 3'd1,
    REQ_REMOVE_ALL = 3'd2,
    REQ_ACTIVATE   = 3'd3,
    REQ_DEACTIVATE = 3'd4,
    REQ_ENABLE     = 3'd5,
    REQ_DISABLE    = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_WALK,
    ST_FINAL
  } ctl_state_e;

  typedef enum logic [2:0] {
    OUT_REPLY,
    OUT_FAIL,
    OUT_SLOT,
    OUT_WALK,
    OUT_FINAL
  } out_kind_e;

  typedef struct packed {
    logic      load;
    logic      walk;
    logic      emit;
    out_kind_e emit_kind;
    logic      slot_fill;
    logic      slot_drop;
    logic      mode_upd;
    logic      patch_upd;
  } dp_cmd_t;

  typedef struct packed {
    req_e req;
    logic enabled;
    logic active;
    logic ev_on;
    logic ev_last;
    logic ev_valid;
    logic ev_match;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bpt_datapath.sv =====
// ----------------------------------------------------------------------------
// bpt_datapath: slot storage, walk pointer, flags and result register
// Holds the slot memories and valid bits, reads one slot per cycle during a
// walk and registers each result item for one strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_datapath #(
  parameter int unsigned SlotCount = bpt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [2:0]       req_type_i,
  input  wire logic [31:0]      address_i,
  input  wire logic [31:0]      original_word_i,
  input  wire bpt_pkg::dp_cmd_t cmd_i,
  output bpt_pkg::dp_stat_t     stat_o,
  output logic                  strobe_o,
  output logic                  write_valid_o,
  output logic [31:0]           write_address_o,
  output logic [31:0]           write_data_o,
  output logic                  icache_invalidate_o,
  output logic                  ok_o,
  output logic                  last_o
);
  import bpt_pkg::*;

  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  req_e            req_q;
  logic [31:0]     addr_q, orig_q;
  logic [IdxW-1:0] rd_idx_q, ev_idx_q;
  logic            rd_pend_q, ev_on_q;
  logic [31:0]     rd_addr_q, rd_orig_q;
  logic [SlotCount-1:0] valid_q;
  logic            enabled_q, active_q;

  logic [31:0] slot_addr_mem [SlotCount];
  logic [31:0] slot_orig_mem [SlotCount];

  logic        wv_d, inv_d, ok_d, last_d;
  logic [31:0] wa_d, wd_d;
  logic        wv_q, inv_q, ok_q, last_q, strobe_q;
  logic [31:0] wa_q, wd_q;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_e'(req_type_i);
      addr_q <= address_i;
      orig_q <= original_word_i;
    end
  end

  // Walk pointer: issue one slot read per cycle, evaluate it the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      ev_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      ev_on_q   <= 1'b0;
    end else if (cmd_i.load) begin
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b1;
      ev_on_q   <= 1'b0;
    end else if (cmd_i.walk) begin
      ev_on_q <= rd_pend_q;
      if (rd_pend_q) begin
        ev_idx_q  <= rd_idx_q;
        rd_pend_q <= (rd_idx_q != LastIdx);
        if (rd_idx_q != LastIdx) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end else begin
      ev_on_q <= 1'b0;
    end
  end

  // Slot memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_fill) begin
      slot_addr_mem[ev_idx_q] <= addr_q;
      slot_orig_mem[ev_idx_q] <= orig_q;
    end
    if (cmd_i.walk && rd_pend_q) begin
      rd_addr_q <= slot_addr_mem[rd_idx_q];
      rd_orig_q <= slot_orig_mem[rd_idx_q];
    end
  end

  // Valid bits and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      enabled_q <= 1'b0;
      active_q  <= 1'b0;
    end else begin
      if (cmd_i.slot_fill) begin
        valid_q[ev_idx_q] <= 1'b1;
      end else if (cmd_i.slot_drop) begin
        valid_q[ev_idx_q] <= 1'b0;
      end
      if (cmd_i.mode_upd) begin
        case (req_q)
          REQ_ENABLE: begin
            enabled_q <= 1'b1;
            active_q  <= 1'b0;
          end
          REQ_DISABLE: begin
            enabled_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.patch_upd) begin
        active_q <= (req_q == REQ_ACTIVATE);
      end
    end
  end

  // Result item
  always_comb begin
    wv_d   = 1'b0;
    wa_d   = 32'd0;
    wd_d   = 32'd0;
    inv_d  = 1'b0;
    ok_d   = 1'b1;
    last_d = 1'b1;
    case (cmd_i.emit_kind)
      OUT_REPLY: begin
        case (req_q)
          REQ_ENABLE:  ok_d = 1'b1;
          REQ_DISABLE: ok_d = 1'b0;
          default:     ok_d = enabled_q;
        endcase
      end
      OUT_FAIL: begin
        ok_d = 1'b0;
      end
      OUT_SLOT: begin
        wv_d = active_q;
        wa_d = addr_q;
        wd_d = (req_q == REQ_SET) ? BKPT_WORD : rd_orig_q;
      end
      OUT_WALK: begin
        wv_d   = 1'b1;
        wa_d   = rd_addr_q;
        wd_d   = (req_q == REQ_ACTIVATE) ? BKPT_WORD : rd_orig_q;
        last_d = 1'b0;
      end
      OUT_FINAL: begin
        inv_d = (req_q == REQ_ACTIVATE) || (req_q == REQ_DEACTIVATE);
      end
      default: begin
      end
    endcase
    // Zero the write fields when no write is made
    if (!wv_d) begin
      wa_d = 32'd0;
      wd_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      wv_q   <= wv_d;
      wa_q   <= wa_d;
      wd_q   <= wd_d;
      inv_q  <= inv_d;
      ok_q   <= ok_d;
      last_q <= last_d;
    end
  end

  assign stat_o.req      = req_q;
  assign stat_o.enabled  = enabled_q;
  assign stat_o.active   = active_q;
  assign stat_o.ev_on    = ev_on_q;
  assign stat_o.ev_last  = (ev_idx_q == LastIdx);
  assign stat_o.ev_valid = valid_q[ev_idx_q];
  assign stat_o.ev_match = (rd_addr_q == addr_q);

  assign strobe_o            = strobe_q;
  assign write_valid_o       = wv_q;
  assign write_address_o     = wa_q;
  assign write_data_o        = wd_q;
  assign icache_invalidate_o = inv_q;
  assign ok_o                = ok_q;
  assign last_o              = last_q;

endmodule

`default_nettype wire

// ===== design/bpt_controller.sv =====
// ----------------------------------------------------------------------------
// bpt_controller: request sequencer for the breakpoint patch table
// Picks a single reply or a slot walk per request and steers the datapath
// through fill, drop, emit and flag commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [2:0]        req_type_i,
  input  wire bpt_pkg::dp_stat_t stat_i,
  output bpt_pkg::dp_cmd_t       cmd_o,
  output logic                   busy
);
  import bpt_pkg::*;

  ctl_state_e state_q, state_d;
  logic       walk_req;
  logic       find_req;
  logic       ev_hit;

  // Requests that walk the slots when the table is enabled
  assign walk_req = (req_e'(req_type_i) == REQ_SET) ||
                    (req_e'(req_type_i) == REQ_REMOVE) ||
                    (req_e'(req_type_i) == REQ_REMOVE_ALL) ||
                    (req_e'(req_type_i) == REQ_ACTIVATE) ||
                    (req_e'(req_type_i) == REQ_DEACTIVATE);

  // Set and remove stop at the first hit
  assign find_req = (stat_i.req == REQ_SET) || (stat_i.req == REQ_REMOVE);
  assign ev_hit   = (stat_i.req == REQ_SET) ? !stat_i.ev_valid
                                            : (stat_i.ev_valid && stat_i.ev_match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (walk_req && stat_i.enabled) ? ST_WALK : ST_REPLY;
        end
      end
      ST_REPLY: begin
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (stat_i.ev_on) begin
          if (find_req) begin
            if (ev_hit || stat_i.ev_last) begin
              state_d = ST_IDLE;
            end
          end else if (stat_i.ev_last) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.emit_kind = OUT_REPLY;
    busy  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_REPLY: begin
        cmd_o.emit     = 1'b1;
        cmd_o.mode_upd = 1'b1;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.ev_on) begin
          case (stat_i.req)
            REQ_SET: begin
              if (ev_hit) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = OUT_SLOT;
                cmd_o.slot_fill = 1'b1;
              end else if (stat_i.ev_last) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = OUT_FAIL;
              end
            end
            REQ_REMOVE: begin
              if (ev_hit) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = OUT_SLOT;
                cmd_o.slot_drop = 1'b1;
              end else if (stat_i.ev_last) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = OUT_FAIL;
              end
            end
            REQ_REMOVE_ALL: begin
              if (stat_i.ev_valid) begin
                cmd_o.slot_drop = 1'b1;
                cmd_o.emit      = stat_i.active;
                cmd_o.emit_kind = OUT_WALK;
              end
            end
            default: begin
              if (stat_i.ev_valid) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = OUT_WALK;
              end
            end
          endcase
        end
      end
      ST_FINAL: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = OUT_FINAL;
        cmd_o.patch_upd = (stat_i.req == REQ_ACTIVATE) ||
                          (stat_i.req == REQ_DEACTIVATE);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/breakpoint_patch_table.sv =====
// ----------------------------------------------------------------------------
// breakpoint_patch_table: software breakpoint slots with memory patch writes
// Keeps SlotCount breakpoint slots plus enabled and activated flags, and turns
// each debugger request into a short run of patch-write result items.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  --------  -----------------  ------------------------------------------------
//  request   start / busy       req_type_i, address_i, original_word_i
//  result    strobe_o (1 cycle) write_valid_o, write_address_o, write_data_o,
//                               icache_invalidate_o, ok_o, last_o
//
//  A request transfers on a rising edge with start high and busy low.
//  Enable, disable, the unused code and any request to a disabled table give
//  one result, emitted from the reply state. Set, remove, remove all, activate
//  and deactivate walk the slots one per cycle through the slot memory read
//  port.
//  Reset clears the valid bits and both flags; slot words need no clearing.
//  Each result holds for one cycle only; the receiver has no way to stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_patch_table #(
  parameter int unsigned SLOT_COUNT = bpt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] original_word_i,
  output logic             strobe_o,
  output logic             write_valid_o,
  output logic [31:0]      write_address_o,
  output logic [31:0]      write_data_o,
  output logic             icache_invalidate_o,
  output logic             ok_o,
  output logic             last_o
);
  import bpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence requests: single reply, slot walk, final item
  bpt_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  // Hold slots and flags, register each result transfer
  bpt_datapath #(
    .SlotCount (SLOT_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_type_i          (req_type_i),
    .address_i           (address_i),
    .original_word_i     (original_word_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .strobe_o            (strobe_o),
    .write_valid_o       (write_valid_o),
    .write_address_o     (write_address_o),
    .write_data_o        (write_data_o),
    .icache_invalidate_o (icache_invalidate_o),
    .ok_o                (ok_o),
    .last_o              (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for breakpoint_patch_table
// Drives set, remove, remove all, activate, deactivate, enable and disable
// requests (plus the unused code) through the start/busy handshake, predicts
// every patch-write result item from a private copy of the slot table and
// flags, and compares each strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpt_pkg::*;

  localparam int unsigned SLOTS       = SLOT_COUNT_DEF;
  localparam int          RAND_ITEMS  = 250;
  localparam int          CALM_TAIL   = 50;    // final requests sent back to back
  localparam int          QUIET_LIMIT = 1000;  // cycles with no transfer at all
  localparam int          DRAIN_WAIT  = SLOTS + 12;
  localparam logic [2:0]  REQ_UNUSED  = 3'd7;

  // One result item as it appears on the result ports.
  typedef struct packed {
    logic        wr_valid;
    logic [31:0] wr_addr;
    logic [31:0] wr_data;
    logic        ic_inval;
    logic        ok;
    logic        last;
  } patch_item_t;

  // --------------------------------------------------------------------------
  // Patch scoreboard: mirrors the slot table, turns each accepted request into
  // the run of patch items it must cause, and checks strobed items in order.
  // --------------------------------------------------------------------------
  class patch_scoreboard;
    logic [31:0] slot_addr [SLOTS];
    logic [31:0] slot_orig [SLOTS];
    bit          slot_valid[SLOTS];
    bit          enabled;
    bit          active;
    patch_item_t pending[$];
    int          errors;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      enabled = 1'b0;
      active  = 1'b0;
      errors  = 0;
    endfunction

    function void queue_result(bit wv, logic [31:0] wa, logic [31:0] wd,
                               bit inv, bit ok, bit last);
      patch_item_t it;
      it.wr_valid = wv;
      it.wr_addr  = wv ? wa : 32'h0;
      it.wr_data  = wv ? wd : 32'h0;
      it.ic_inval = inv;
      it.ok       = ok;
      it.last     = last;
      pending.push_back(it);
    endfunction

    function void note_request(logic [2:0] req, logic [31:0] addr, logic [31:0] orig);
      bit done;
      done = 1'b0;
      case (req)
        REQ_ENABLE: begin
          enabled = 1'b1;
          active  = 1'b0;
          queue_result(0, 0, 0, 0, 1, 1);
        end
        REQ_DISABLE: begin
          enabled = 1'b0;
          queue_result(0, 0, 0, 0, 0, 1);
        end
        REQ_SET, REQ_REMOVE, REQ_REMOVE_ALL, REQ_ACTIVATE, REQ_DEACTIVATE: begin
          if (!enabled) begin
            queue_result(0, 0, 0, 0, 0, 1);
          end else if (req == REQ_SET) begin
            // first free slot takes the breakpoint
            for (int i = 0; i < SLOTS; i++) begin
              if (!done && !slot_valid[i]) begin
                slot_valid[i] = 1'b1;
                slot_addr[i]  = addr;
                slot_orig[i]  = orig;
                queue_result(active, addr, BKPT_WORD, 0, 1, 1);
                done = 1'b1;
              end
            end
            if (!done) queue_result(0, 0, 0, 0, 0, 1);
          end else if (req == REQ_REMOVE) begin
            // lowest matching valid slot is cleared
            for (int i = 0; i < SLOTS; i++) begin
              if (!done && slot_valid[i] && slot_addr[i] == addr) begin
                slot_valid[i] = 1'b0;
                queue_result(active, addr, slot_orig[i], 0, 1, 1);
                done = 1'b1;
              end
            end
            if (!done) queue_result(0, 0, 0, 0, 0, 1);
          end else if (req == REQ_REMOVE_ALL) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_valid[i]) begin
                if (active) queue_result(1, slot_addr[i], slot_orig[i], 0, 1, 0);
                slot_valid[i] = 1'b0;
              end
            end
            queue_result(0, 0, 0, 0, 1, 1);
          end else begin
            // activate / deactivate rewrite every valid slot, then invalidate
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_valid[i])
                queue_result(1, slot_addr[i],
                             (req == REQ_ACTIVATE) ? BKPT_WORD : slot_orig[i], 0, 1, 0);
            end
            active = (req == REQ_ACTIVATE);
            queue_result(0, 0, 0, 1, 1, 1);
          end
        end
        default: queue_result(0, 0, 0, 0, enabled, 1);
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(patch_item_t got);
      patch_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        compare_field("write_valid",       want.wr_valid, got.wr_valid);
        compare_field("write_address",     want.wr_addr,  got.wr_addr);
        compare_field("write_data",        want.wr_data,  got.wr_data);
        compare_field("icache_invalidate", want.ic_inval, got.ic_inval);
        compare_field("ok",                want.ok,       got.ok);
        compare_field("last",              want.last,     got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  req_type_i;
  logic [31:0] address_i;
  logic [31:0] original_word_i;
  logic        strobe_o;
  logic        write_valid_o;
  logic [31:0] write_address_o;
  logic [31:0] write_data_o;
  logic        icache_invalidate_o;
  logic        ok_o;
  logic        last_o;

  breakpoint_patch_table #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type_i),
    .address_i          (address_i),
    .original_word_i    (original_word_i),
    .strobe_o           (strobe_o),
    .write_valid_o      (write_valid_o),
    .write_address_o    (write_address_o),
    .write_data_o       (write_data_o),
    .icache_invalidate_o(icache_invalidate_o),
    .ok_o               (ok_o),
    .last_o             (last_o)
  );

  patch_scoreboard sb = new();

  bit took_item;        // request transfer seen at the latest rising edge
  int quiet_cycles = 0; // edges since the last transfer on either channel
  bit gaps_on;          // sender may insert idle bursts

  // Free-running clock, 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check the result first,
  // then note the request, so a new expectation never pairs with an old item.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    took_item = rst_ni && start && !busy;
    if (rst_ni && strobe_o)
      sb.check_result({write_valid_o, write_address_o, write_data_o,
                       icache_invalidate_o, ok_o, last_o});
    if (took_item)
      sb.note_request(req_type_i, address_i, original_word_i);
    if (took_item || (rst_ni && strobe_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // Watchdog: a stuck handshake or a missing result ends the run.
  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // Mix of fixed corner values, a small pool that forces duplicates, and
  // fully random words so every address bit toggles.
  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_1000 + 32'(4 * $urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Present one request from a falling edge, hold it until the transfer, then
  // maybe drop start for a random idle burst. Always returns on a falling edge.
  task automatic issue_request(logic [2:0] req, logic [31:0] addr, logic [31:0] orig);
    start           = 1'b1;
    req_type_i      = req;
    address_i       = addr;
    original_word_i = orig;
    do @(negedge clk_i); while (!took_item);
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      start           = 1'b0;
      req_type_i      = 3'($urandom);
      address_i       = $urandom;
      original_word_i = $urandom;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every expected item has arrived.
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // Random phase: mostly a live, enabled table with sets, matching removes and
  // activate/deactivate walks; the rest disables, stray codes and misses.
  task automatic run_random();
    int          roll;
    logic [2:0]  req;
    logic [31:0] addr;
    logic [31:0] orig;
    int          live[$];
    for (int n = 0; n < RAND_ITEMS; n++) begin
      gaps_on = (n < RAND_ITEMS - CALM_TAIL);
      if (n == RAND_ITEMS / 3) drain_results();
      addr = pick_address();
      orig = ($urandom_range(0, 9) == 0) ? {32{1'($urandom)}} : $urandom;
      roll = $urandom_range(0, 99);
      if (!sb.enabled && roll < 85)  req = REQ_ENABLE;
      else if (roll < 34)            req = REQ_SET;
      else if (roll < 60)            req = REQ_REMOVE;
      else if (roll < 66)            req = REQ_REMOVE_ALL;
      else if (roll < 79)            req = REQ_ACTIVATE;
      else if (roll < 88)            req = REQ_DEACTIVATE;
      else if (roll < 93)            req = REQ_ENABLE;
      else if (roll < 97)            req = REQ_DISABLE;
      else                           req = REQ_UNUSED;
      // aim most removes at a breakpoint that is really there
      if (req == REQ_REMOVE && $urandom_range(0, 99) < 75) begin
        live.delete();
        for (int i = 0; i < SLOTS; i++) if (sb.slot_valid[i]) live.push_back(i);
        if (live.size() != 0) addr = sb.slot_addr[live[$urandom_range(0, live.size() - 1)]];
      end
      issue_request(req, addr, orig);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = 3'd0;
    address_i       = 32'h0;
    original_word_i = 32'h0;
    gaps_on         = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: disabled table rejects everything but enable
    issue_request(REQ_SET,        32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(REQ_ACTIVATE,   32'h0,         32'h0);
    issue_request(REQ_UNUSED,     32'h0,         32'h0);
    issue_request(REQ_ENABLE,     32'h0,         32'h0);
    // miss on empty table; address zero is ordinary
    issue_request(REQ_REMOVE,     32'h0,         32'h0);
    // duplicate addresses with extreme words
    issue_request(REQ_SET,        32'h0,         32'hFFFF_FFFF);
    issue_request(REQ_SET,        32'hFFFF_FFFF, 32'h0);
    issue_request(REQ_SET,        32'h0,         32'h1234_5678);
    issue_request(REQ_ACTIVATE,   32'h0,         32'h0);
    // changes while patches are live emit writes
    issue_request(REQ_SET,        32'h8000_0000, 32'hA5A5_5A5A);
    issue_request(REQ_REMOVE,     32'h0,         32'h0);
    issue_request(REQ_REMOVE,     32'h0000_1234, 32'h0);
    // repeated walks rewrite the slots anyway
    issue_request(REQ_ACTIVATE,   32'h0,         32'h0);
    issue_request(REQ_DEACTIVATE, 32'h0,         32'h0);
    issue_request(REQ_DEACTIVATE, 32'h0,         32'h0);
    // fill the table, then one more set must fail
    for (int i = 0; i < 5; i++) issue_request(REQ_SET, $urandom, $urandom);
    issue_request(REQ_SET,        32'hDEAD_BEEF, 32'h0);
    issue_request(REQ_ACTIVATE,   32'h0,         32'h0);
    issue_request(REQ_UNUSED,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // disable keeps slots and activation; enable clears activation
    issue_request(REQ_DISABLE,    32'h0,         32'h0);
    issue_request(REQ_REMOVE_ALL, 32'h0,         32'h0);
    issue_request(REQ_ENABLE,     32'h0,         32'h0);
    issue_request(REQ_REMOVE_ALL, 32'h0,         32'h0);

    run_random();

    // Let the last walk finish and make sure nothing stray follows.
    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
